// File: src/acf_pkg.sv
// shared types, constants and a helper function for the affine cipher block
`timescale 1ns / 1ps

package acf_pkg;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  localparam logic [8:0] SIZE_RESET = 9'd26;

  localparam int PROD_W     = 25;
  localparam int MOD_STEPS  = 4;
  localparam int MOD_STAGES = (PROD_W + MOD_STEPS - 1) / MOD_STEPS;
  localparam int DIV_W      = MOD_STAGES * MOD_STEPS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULT_KEY       = 3'd0,
    REG_SHIFT_KEY      = 3'd1,
    REG_INVERSE_KEY    = 3'd2,
    REG_ALPHABET_SIZE  = 3'd3,
    REG_CASE_SENSITIVE = 3'd4,
    REG_DECRYPT_MODE   = 3'd5
  } reg_idx_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_XFORM = 1'b1
  } req_e;

  typedef struct packed {
    logic [7:0] mult;
    logic [7:0] shift;
    logic [7:0] inv;
    logic [8:0] n_eff;
    logic       case_sens;
    logic       decrypt;
  } cfg_t;

  typedef struct packed {
    logic       xform;
    logic       hit;
    logic       dup;
    logic       wr;
    logic       fold;
    logic [7:0] ch;
    logic [7:0] key;
    logic [7:0] pos;
  } item_t;

  // one restoring step of a remainder by n
  function automatic logic [7:0] mod_step(input logic [7:0] rem, input logic b,
                                          input logic [8:0] n);
    logic [8:0] t;
    t = {rem, b};
    if (t >= n) begin
      t = t - n;
    end
    return t[7:0];
  endfunction

endpackage

// File: src/acf_front.sv
// input stage, symbol map lookup and update, affine multiply
`timescale 1ns / 1ps

module acf_front
  import acf_pkg::*;
#(
  parameter int ALPHABET_MAX = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic             req_i,
  input  logic [7:0]       ch_i,
  input  logic [7:0]       pos_i,
  input  cfg_t             cfg_i,
  output logic             vld_o,
  output logic [DIV_W-1:0] dvd_o,
  output item_t            item_o
);

  localparam int TIDX_W = $clog2(ALPHABET_MAX);
  localparam logic [8:0] NMAX = 9'(ALPHABET_MAX);

  logic [TIDX_W-1:0] map_idx_mem [256];
  logic [255:0]      map_vld_q;

  logic       fold_d;
  logic [7:0] key_d;

  logic              v1_q;
  logic              xf1_q;
  logic              fold1_q;
  logic [7:0]        ch1_q;
  logic [7:0]        key1_q;
  logic [7:0]        pos1_q;
  logic              fwd1_q;
  logic [TIDX_W-1:0] fwdpos1_q;
  logic [TIDX_W-1:0] mrd1_q;

  logic              hit1;
  logic              wr1;
  logic [TIDX_W-1:0] idx1;
  logic [7:0]        idx1_b;
  logic [16:0]       opx1;
  logic [7:0]        opm1;
  logic [7:0]        add1;
  item_t             item1;

  logic        v2_q;
  item_t       item2_q;
  logic [16:0] opx2_q;
  logic [7:0]  opm2_q;
  logic [7:0]  add2_q;
  logic [PROD_W-1:0] prod2;

  logic              v3_q;
  item_t             item3_q;
  logic [PROD_W-1:0] prod3_q;

  always_comb begin
    fold_d = !cfg_i.case_sens && (ch_i >= CH_UPPER_A) && (ch_i <= CH_UPPER_Z);
    key_d  = fold_d ? (ch_i + CASE_GAP) : ch_i;
  end

  // stage one: map state is current, last write forwarded past the memory
  always_comb begin
    hit1   = map_vld_q[key1_q];
    idx1   = fwd1_q ? fwdpos1_q : mrd1_q;
    idx1_b = 8'(idx1);
    wr1    = v1_q && !xf1_q && !hit1 && ({1'b0, pos1_q} < NMAX);
    if (cfg_i.decrypt) begin
      opx1 = 17'(idx1_b) + {cfg_i.n_eff, 8'h00} - 17'(cfg_i.shift);
      opm1 = cfg_i.inv;
      add1 = '0;
    end else begin
      opx1 = 17'(idx1_b);
      opm1 = cfg_i.mult;
      add1 = cfg_i.shift;
    end
    item1.xform = xf1_q;
    item1.hit   = hit1;
    item1.dup   = !xf1_q && hit1;
    item1.wr    = wr1;
    item1.fold  = fold1_q;
    item1.ch    = ch1_q;
    item1.key   = key1_q;
    item1.pos   = pos1_q;
  end

  assign prod2 = PROD_W'(opx2_q) * PROD_W'(opm2_q) + PROD_W'(add2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      map_vld_q <= '0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (wr1) begin
        map_vld_q[key1_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xf1_q     <= (req_i == REQ_XFORM);
      fold1_q   <= fold_d;
      ch1_q     <= ch_i;
      key1_q    <= key_d;
      pos1_q    <= pos_i;
      fwd1_q    <= wr1 && (key1_q == key_d);
      fwdpos1_q <= pos1_q[TIDX_W-1:0];
      mrd1_q    <= map_idx_mem[key_d];
      if (wr1) begin
        map_idx_mem[key1_q] <= pos1_q[TIDX_W-1:0];
      end
      item2_q <= item1;
      opx2_q  <= opx1;
      opm2_q  <= opm1;
      add2_q  <= add1;
      item3_q <= item2_q;
      prod3_q <= prod2;
    end
  end

  assign vld_o  = v3_q;
  assign dvd_o  = DIV_W'(prod3_q);
  assign item_o = item3_q;

endmodule

// File: src/acf_mod_pipe.sv
// pipelined restoring remainder by the alphabet size
`timescale 1ns / 1ps

module acf_mod_pipe
  import acf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [8:0]       n_i,
  input  logic             vld_i,
  input  logic [DIV_W-1:0] dvd_i,
  input  item_t            item_i,
  output logic             vld_o,
  output logic [7:0]       rem_o,
  output item_t            item_o
);

  logic             vld_q  [MOD_STAGES];
  logic [7:0]       rem_q  [MOD_STAGES];
  logic [DIV_W-1:0] dvd_q  [MOD_STAGES];
  item_t            item_q [MOD_STAGES];

  logic             vld_in  [MOD_STAGES];
  logic [7:0]       rem_in  [MOD_STAGES];
  logic [DIV_W-1:0] dvd_in  [MOD_STAGES];
  item_t            item_in [MOD_STAGES];
  logic [7:0]       rem_d   [MOD_STAGES];

  always_comb begin
    vld_in[0]  = vld_i;
    rem_in[0]  = '0;
    dvd_in[0]  = dvd_i;
    item_in[0] = item_i;
    for (int s = 1; s < MOD_STAGES; s++) begin
      vld_in[s]  = vld_q[s-1];
      rem_in[s]  = rem_q[s-1];
      dvd_in[s]  = dvd_q[s-1];
      item_in[s] = item_q[s-1];
    end
    // each stage consumes MOD_STEPS dividend bits, msb first
    for (int s = 0; s < MOD_STAGES; s++) begin
      rem_d[s] = rem_in[s];
      for (int k = 0; k < MOD_STEPS; k++) begin
        rem_d[s] = mod_step(rem_d[s], dvd_in[s][DIV_W-1-s*MOD_STEPS-k], n_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MOD_STAGES; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      for (int s = 0; s < MOD_STAGES; s++) begin
        vld_q[s] <= vld_in[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < MOD_STAGES; s++) begin
        rem_q[s]  <= rem_d[s];
        dvd_q[s]  <= dvd_in[s];
        item_q[s] <= item_in[s];
      end
    end
  end

  assign vld_o  = vld_q[MOD_STAGES-1];
  assign rem_o  = rem_q[MOD_STAGES-1];
  assign item_o = item_q[MOD_STAGES-1];

endmodule

// File: src/acf_back.sv
// symbol table access, case restore and output register
`timescale 1ns / 1ps

module acf_back
  import acf_pkg::*;
#(
  parameter int ALPHABET_MAX = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       vld_i,
  input  logic [7:0] rem_i,
  input  item_t      item_i,
  output logic       out_vld_o,
  output logic [7:0] char_o,
  output logic       in_alpha_o,
  output logic       dup_o
);

  localparam int TIDX_W = $clog2(ALPHABET_MAX);

  logic [7:0] tbl_mem [ALPHABET_MAX];
  logic [7:0] trd_q;
  logic       vb_q;
  item_t      itemb_q;

  logic [7:0] sym;
  logic [7:0] char_d;

  logic       out_vld_q;
  logic [7:0] char_q;
  logic       in_alpha_q;
  logic       dup_q;

  // loads and reads share this stage so table order follows item order
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (vld_i && item_i.wr) begin
        tbl_mem[item_i.pos[TIDX_W-1:0]] <= item_i.key;
      end
      trd_q   <= tbl_mem[rem_i[TIDX_W-1:0]];
      itemb_q <= item_i;
    end
  end

  always_comb begin
    sym = trd_q;
    if (itemb_q.fold && (trd_q >= CH_LOWER_A) && (trd_q <= CH_LOWER_Z)) begin
      sym = trd_q - CASE_GAP;
    end
    if (!itemb_q.xform) begin
      char_d = '0;
    end else if (!itemb_q.hit) begin
      char_d = itemb_q.ch;
    end else begin
      char_d = sym;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vb_q      <= vld_i;
      out_vld_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      char_q     <= char_d;
      in_alpha_q <= itemb_q.xform && itemb_q.hit;
      dup_q      <= itemb_q.dup;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign char_o     = char_q;
  assign in_alpha_o = in_alpha_q;
  assign dup_o      = dup_q;

endmodule

// File: src/affine_cipher_alphabet.sv
// affine cipher over a loadable byte alphabet, top level
// a result word passes the front stages, the remainder pipeline and the back stages in order
// throughput: one word per cycle while the output is not stalled, through the 7-stage remainder pipeline
// a stall on the output holds every stage, input ready follows output space
// reset sets the config registers to their defaults and clears stage valids and all map valid bits at once
`timescale 1ns / 1ps

module affine_cipher_alphabet
  import acf_pkg::*;
#(
  parameter int ALPHABET_MAX = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [15:0]           s_axis_tdata_i,   // char_in, entry_index
  input  logic [0:0]            s_axis_tuser_i,   // req_type
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,   // char_out
  output logic [1:0]            m_axis_tuser_o,   // in_alphabet, dup_error
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [8:0] NMAX   = 9'(ALPHABET_MAX);
  localparam logic [8:0] NRESET = (NMAX < SIZE_RESET) ? NMAX : SIZE_RESET;

  cfg_t       cfg_q;
  logic [8:0] n_w;
  logic       en;

  logic             f_vld;
  logic [DIV_W-1:0] f_dvd;
  item_t            f_item;
  logic             m_vld;
  logic [7:0]       m_rem;
  item_t            m_item;

  logic       b_vld;
  logic [7:0] b_char;
  logic       b_in_alpha;
  logic       b_dup;

  // stored size is already clamped to the legal range
  always_comb begin
    if (cfg_data_i == '0) begin
      n_w = 9'd1;
    end else if (cfg_data_i > NMAX) begin
      n_w = NMAX;
    end else begin
      n_w = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mult      <= 8'd1;
      cfg_q.shift     <= 8'd0;
      cfg_q.inv       <= 8'd1;
      cfg_q.n_eff     <= NRESET;
      cfg_q.case_sens <= 1'b1;
      cfg_q.decrypt   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MULT_KEY:       cfg_q.mult      <= cfg_data_i[7:0];
        REG_SHIFT_KEY:      cfg_q.shift     <= cfg_data_i[7:0];
        REG_INVERSE_KEY:    cfg_q.inv       <= cfg_data_i[7:0];
        REG_ALPHABET_SIZE:  cfg_q.n_eff     <= n_w;
        REG_CASE_SENSITIVE: cfg_q.case_sens <= cfg_data_i[0];
        REG_DECRYPT_MODE:   cfg_q.decrypt   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign en              = !b_vld || m_axis_tready_i;
  assign s_axis_tready_o = en;

  acf_front #(
    .ALPHABET_MAX(ALPHABET_MAX)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid_i),
    .req_i  (s_axis_tuser_i[0]),
    .ch_i   (s_axis_tdata_i[7:0]),
    .pos_i  (s_axis_tdata_i[15:8]),
    .cfg_i  (cfg_q),
    .vld_o  (f_vld),
    .dvd_o  (f_dvd),
    .item_o (f_item)
  );

  acf_mod_pipe u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .n_i    (cfg_q.n_eff),
    .vld_i  (f_vld),
    .dvd_i  (f_dvd),
    .item_i (f_item),
    .vld_o  (m_vld),
    .rem_o  (m_rem),
    .item_o (m_item)
  );

  acf_back #(
    .ALPHABET_MAX(ALPHABET_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (m_vld),
    .rem_i      (m_rem),
    .item_i     (m_item),
    .out_vld_o  (b_vld),
    .char_o     (b_char),
    .in_alpha_o (b_in_alpha),
    .dup_o      (b_dup)
  );

  assign m_axis_tvalid_o = b_vld;
  assign m_axis_tdata_o  = b_char;
  assign m_axis_tuser_o  = {b_dup, b_in_alpha};

endmodule

// File: src/acf_checker.sv
// port-level checks for the affine cipher block, bound to the top level
`timescale 1ns / 1ps

module acf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [1:0] m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("in_alphabet and dup_error both set");

  a_dup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tdata_o == 8'h00)
    else $error("load result carries nonzero char");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

endmodule

bind affine_cipher_alphabet acf_checker u_acf_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the affine cipher block: alphabet loads and byte transforms

module tb;
  import acf_pkg::*;

  localparam int LATENCY     = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PHASES = 11;
  localparam int PHASE_WORDS = 150;
  localparam int SYM_MAX     = 256;

  typedef struct {
    req_e       req;
    logic [7:0] ch;
    logic [7:0] pos;
  } byte_req_t;

  typedef struct {
    logic [7:0] ch_out;
    logic       in_alpha;
    logic       dup;
  } cipher_out_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  s_valid  = 1'b0;
  logic                  s_ready;
  logic [15:0]           s_data   = '0;
  logic [0:0]            s_user   = '0;
  logic                  m_valid;
  logic                  m_ready  = 1'b0;
  logic [7:0]            m_data;
  logic [1:0]            m_user;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // queues fill at the front and drain from the back
  byte_req_t   req_q[$];
  cipher_out_t cipher_out_q[$];
  int          err_cnt = 0;

  // shadow of the key registers
  logic [7:0] mult_r      = 8'd1;
  logic [7:0] shift_r     = 8'd0;
  logic [7:0] inv_r       = 8'd1;
  logic [8:0] size_r      = SIZE_RESET;
  logic       case_sens_r = 1'b1;
  logic       decrypt_r   = 1'b0;

  // shadow of the alphabet
  logic       map_valid [SYM_MAX];
  logic [7:0] map_idx   [SYM_MAX];
  logic [7:0] sym_table [SYM_MAX];
  logic       pos_used  [SYM_MAX];
  logic [7:0] loaded_keys[$];

  always #5 clk = ~clk;

  affine_cipher_alphabet i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  function automatic cipher_out_t cipher_step(byte_req_t w);
    cipher_out_t res;
    logic        fold;
    logic [7:0]  key;
    logic [7:0]  sym;
    int          n, i, r, d;
    fold = !case_sens_r && w.ch >= CH_UPPER_A && w.ch <= CH_UPPER_Z;
    key  = fold ? w.ch + CASE_GAP : w.ch;
    res  = '{8'h00, 1'b0, 1'b0};
    if (w.req == REQ_LOAD) begin
      if (map_valid[key]) begin
        res.dup = 1'b1;
      end else begin
        map_valid[key]   = 1'b1;
        map_idx[key]     = w.pos;
        sym_table[w.pos] = key;
        pos_used[w.pos]  = 1'b1;
        loaded_keys.push_front(key);
      end
    end else if (!map_valid[key]) begin
      res.ch_out = w.ch;
    end else begin
      n = (size_r == 9'd0) ? 1 : ((int'(size_r) > SYM_MAX) ? SYM_MAX : int'(size_r));
      i = int'(map_idx[key]) % n;
      if (!decrypt_r) begin
        r = ((int'(mult_r) % n) * i + int'(shift_r) % n) % n;
      end else begin
        d = (i + n - int'(shift_r) % n) % n;
        r = (d * (int'(inv_r) % n)) % n;
      end
      sym = sym_table[r];
      if (fold && sym >= CH_LOWER_A && sym <= CH_LOWER_Z) begin
        sym = sym - CASE_GAP;
      end
      res.ch_out   = sym;
      res.in_alpha = 1'b1;
    end
    return res;
  endfunction

  task automatic queue_word(req_e req, logic [7:0] ch, logic [7:0] pos);
    byte_req_t w;
    w.req = req;
    w.ch  = ch;
    w.pos = pos;
    cipher_out_q.push_front(cipher_step(w));
    req_q.push_front(w);
  endtask

  function automatic int written_prefix();
    int k;
    for (k = 0; k < SYM_MAX; k++) begin
      if (!pos_used[k]) return k;
    end
    return SYM_MAX;
  endfunction

  function automatic logic [7:0] free_pos(bit lowest);
    int p, k;
    p = lowest ? 0 : $urandom_range(0, SYM_MAX - 1);
    for (k = 0; k < SYM_MAX; k++) begin
      if (!pos_used[(p + k) % SYM_MAX]) return 8'((p + k) % SYM_MAX);
    end
    return 8'(p);
  endfunction

  function automatic int idle_len(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [7:0] pick_byte(int lo);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'(lo);
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(lo, 255));
  endfunction

  // new symbols only take free positions, so the table fills without overwrites
  task automatic load_random();
    logic [7:0] ch;
    logic [7:0] key;
    ch  = 8'($urandom_range(0, 255));
    key = (!case_sens_r && ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ? ch + CASE_GAP : ch;
    if (map_valid[key]) begin
      queue_word(REQ_LOAD, ch, 8'($urandom_range(0, 255)));
    end else begin
      queue_word(REQ_LOAD, ch, free_pos($urandom_range(0, 99) < 60));
    end
  endtask

  task automatic xform_random();
    logic [7:0] ch;
    if (loaded_keys.size() > 0 && $urandom_range(0, 1)) begin
      ch = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z && $urandom_range(0, 1)) begin
        ch = ch - CASE_GAP;
      end
    end else begin
      ch = 8'($urandom_range(0, 255));
    end
    queue_word(REQ_XFORM, ch, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || cipher_out_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [8:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    unique case (idx)
      REG_MULT_KEY:       mult_r      = val[7:0];
      REG_SHIFT_KEY:      shift_r     = val[7:0];
      REG_INVERSE_KEY:    inv_r       = val[7:0];
      REG_ALPHABET_SIZE:  size_r      = val;
      REG_CASE_SENSITIVE: case_sens_r = val[0];
      REG_DECRYPT_MODE:   decrypt_r   = val[0];
      default: ;
    endcase
  endtask

  // called with an n of at most the written table prefix, or above it once the whole table is written
  task automatic reconfigure(logic [7:0] mult, logic [7:0] shift, logic [7:0] inv,
                             logic [8:0] n, logic cs, logic dec);
    wait_idle();
    write_reg(REG_MULT_KEY, {1'b0, mult});
    write_reg(REG_SHIFT_KEY, {1'b0, shift});
    write_reg(REG_INVERSE_KEY, {1'b0, inv});
    write_reg(REG_ALPHABET_SIZE, n);
    write_reg(REG_CASE_SENSITIVE, {8'd0, cs});
    write_reg(REG_DECRYPT_MODE, {8'd0, dec});
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int         ph, k, p, r;
    logic [8:0] n;
    int         big_sizes[3];
    big_sizes = '{256, 511, 300};
    for (k = 0; k < SYM_MAX; k++) begin
      map_valid[k] = 1'b0;
      map_idx[k]   = 8'd0;
      sym_table[k] = 8'd0;
      pos_used[k]  = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset keys: identity over a small alphabet
    queue_word(REQ_LOAD, "a", 8'd0);
    queue_word(REQ_LOAD, "b", 8'd1);
    queue_word(REQ_LOAD, "c", 8'd2);
    queue_word(REQ_LOAD, "Z", 8'd3);
    queue_word(REQ_LOAD, 8'hFF, 8'd4);
    queue_word(REQ_LOAD, 8'h00, 8'd5);
    queue_word(REQ_LOAD, 8'h80, 8'd255);
    queue_word(REQ_LOAD, "a", 8'd255);
    queue_word(REQ_XFORM, "b", 8'd0);
    queue_word(REQ_XFORM, "A", 8'd255);
    queue_word(REQ_XFORM, 8'hFF, 8'd0);
    queue_word(REQ_XFORM, "Z", 8'd0);

    // folded case, index beyond size
    reconfigure(8'd5, 8'd1, 8'd5, 9'd6, 1'b0, 1'b0);
    queue_word(REQ_XFORM, "A", 8'd0);
    queue_word(REQ_XFORM, "Z", 8'd0);
    queue_word(REQ_LOAD, "C", 8'd7);
    queue_word(REQ_LOAD, "Q", 8'd6);
    queue_word(REQ_XFORM, 8'h80, 8'd0);

    // size zero acts as one, extreme keys
    reconfigure(8'd255, 8'd255, 8'd255, 9'd0, 1'b0, 1'b1);
    queue_word(REQ_XFORM, "Q", 8'd0);
    queue_word(REQ_XFORM, 8'h00, 8'd0);

    reconfigure(8'd3, 8'd2, 8'd5, 9'd7, 1'b1, 1'b1);
    queue_word(REQ_XFORM, "q", 8'd0);
    queue_word(REQ_XFORM, "c", 8'd0);
    queue_word(REQ_XFORM, "Z", 8'd0);

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      p = written_prefix();
      r = $urandom_range(0, 9);
      n = (r == 0) ? 9'd0 : ((r == 1) ? 9'(p) : 9'($urandom_range(1, p)));
      reconfigure(pick_byte(1), pick_byte(0), pick_byte(1), n,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(0, 99) < 18) load_random();
        else xform_random();
      end
    end

    // fill the whole alphabet so the largest sizes are safe
    reconfigure(pick_byte(1), pick_byte(0), pick_byte(1), 9'(written_prefix()), 1'b1,
                1'($urandom_range(0, 1)));
    for (k = 0; k < SYM_MAX; k++) begin
      if (!map_valid[k]) begin
        queue_word(REQ_LOAD, 8'(k), free_pos(1'b1));
      end
      if ($urandom_range(0, 3) == 0) xform_random();
    end

    for (ph = 0; ph < 3; ph++) begin
      reconfigure(pick_byte(1), pick_byte(0), pick_byte(1), 9'(big_sizes[ph]),
                  1'($urandom_range(0, 1)), ph[0]);
      for (k = 0; k < 80; k++) begin
        if ($urandom_range(0, 9) == 0) load_random();
        else xform_random();
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("PASS affine_cipher_alphabet");
    end else begin
      $display("FAIL affine_cipher_alphabet");
    end
    $finish;
  end

  int src_gap   = 0;
  bit src_quiet = 1'b0;

  always @(posedge clk) begin : drive_src
    byte_req_t w;
    if (rst_n && (!s_valid || s_ready)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        w = req_q.pop_back();
        s_valid <= 1'b1;
        s_data  <= {w.pos, w.ch};
        s_user  <= w.req;
        src_gap <= idle_len(src_quiet);
        if ($urandom_range(0, 99) == 0) src_quiet <= !src_quiet;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  int snk_stall = 0;
  bit snk_quiet = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else if (snk_stall > 0) begin
      snk_stall <= snk_stall - 1;
      m_ready   <= 1'b0;
    end else if (!snk_quiet && $urandom_range(0, 99) < 15) begin
      snk_stall <= idle_len(1'b0);
      m_ready   <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
    if ($urandom_range(0, 299) == 0) snk_quiet <= !snk_quiet;
  end

  always @(posedge clk) begin : check_out
    cipher_out_t e;
    if (rst_n && m_valid && m_ready) begin
      if (cipher_out_q.size() == 0) begin
        $error("unexpected result word: char_out %02h", m_data);
        err_cnt++;
      end else begin
        e = cipher_out_q.pop_back();
        if (m_data !== e.ch_out) begin
          $error("char_out: expected %02h, actual %02h", e.ch_out, m_data);
          err_cnt++;
        end
        if (m_user[0] !== e.in_alpha) begin
          $error("in_alphabet: expected %0b, actual %0b", e.in_alpha, m_user[0]);
          err_cnt++;
        end
        if (m_user[1] !== e.dup) begin
          $error("dup_error: expected %0b, actual %0b", e.dup, m_user[1]);
          err_cnt++;
        end
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL affine_cipher_alphabet");
      $finish;
    end
  end

endmodule

// File: sim.f
src/acf_pkg.sv
src/acf_front.sv
src/acf_mod_pipe.sv
src/acf_back.sv
src/affine_cipher_alphabet.sv
src/acf_checker.sv
tb/sv/tb.sv
